// ===== sv/modular_exponentiation_defines.svh =====
// ----------------------------------------------------------------------------
// Modular exponentiation assertion macros
// Shared property wrappers for the modular exponentiation RTL. Each macro
// is clocked on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_DEFINES_SVH
`define MODULAR_EXPONENTIATION_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MEXP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MEXP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/mexp_pkg.sv =====
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Shared widths, register indexes and the status bundle of the shared
// modular multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

package mexp_pkg;

  // Default modulus and base width.
  localparam int MODULUS_BITS_DEF = 31;

  // Exponent register width.
  localparam int EXP_BITS = 32;

  // Width of the configuration register index.
  localparam int CFG_INDEX_BITS = 1;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_EXPONENT = 1'b0,
    REG_MODULUS  = 1'b1
  } cfg_reg_t;

  // Status of the shared modular multiplier.
  typedef struct packed {
    logic busy;
    logic done;
  } mul_status_t;

endpackage

`default_nettype wire

// ===== sv/mexp_mulmod.sv =====
// ----------------------------------------------------------------------------
// Shared modular multiplier
// Interleaved shift-and-add modular multiplication, scanning the multiplier
// from its most significant bit, one bit per cycle. The multiplicand must
// already be below the modulus; the multiplier may hold any value.
// ----------------------------------------------------------------------------
`default_nettype none
`include "modular_exponentiation_defines.svh"

module mexp_mulmod #(
  parameter int W = mexp_pkg::MODULUS_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [W-1:0]          x,
  input  wire logic [W-1:0]          y,
  input  wire logic [W-1:0]          m,
  output      logic [W-1:0]          product,
  output      mexp_pkg::mul_status_t status
);

  localparam int CW = $clog2(W);

  logic [W-1:0]  acc;
  logic [W-1:0]  xr;
  logic [W-1:0]  yr;
  logic [W-1:0]  mr;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          done;

  logic [W+1:0]  sum;
  logic [W+1:0]  m1;
  logic [W+1:0]  m2;
  logic [W+1:0]  diff1;
  logic [W+1:0]  diff2;
  logic [W-1:0]  acc_next;

  // One step: double the partial product, add the multiplicand when the
  // current multiplier bit is set, then subtract the modulus up to twice.
  always_comb begin
    sum   = {1'b0, acc, 1'b0} + (yr[W-1] ? {2'b00, xr} : {(W+2){1'b0}});
    m1    = {2'b00, mr};
    m2    = {1'b0, mr, 1'b0};
    diff1 = sum - m1;
    diff2 = sum - m2;
    if (sum >= m2) begin
      acc_next = diff2[W-1:0];
    end else if (sum >= m1) begin
      acc_next = diff1[W-1:0];
    end else begin
      acc_next = sum[W-1:0];
    end
  end

  // Operand capture and step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      if (start) begin
        acc  <= '0;
        xr   <= x;
        yr   <= y;
        mr   <= m;
        cnt  <= CW'(W - 1);
        busy <= 1'b1;
        done <= 1'b0;
      end else if (busy) begin
        acc  <= acc_next;
        yr   <= {yr[W-2:0], 1'b0};
        cnt  <= cnt - CW'(1);
        busy <= (cnt != '0);
        done <= (cnt == '0);
      end else begin
        done <= 1'b0;
      end
    end
  end

  assign product     = acc;
  assign status.busy = busy;
  assign status.done = done;

  // A new product is never started over one still in progress.
  `MEXP_ASSERT_SAME(a_no_start_when_busy, start, !busy, "multiplier started while busy")
  // A finished product is always fully reduced.
  `MEXP_ASSERT_SAME(a_product_reduced, done, acc < mr, "product not below modulus")
  // The last step always raises done in the following cycle.
  `MEXP_ASSERT_NEXT(a_done_after_last, busy && !start && cnt == '0, done && !busy,
                    "done missing after last step")

endmodule

`default_nettype wire

// ===== sv/modular_exponentiation.sv =====
// Each word takes a reduction of the base and then, for each exponent bit up to the highest
// set one, a multiply when the bit is set and a squaring, the final squaring skipped; a
// modulus of zero skips all of them. A new base word is accepted only while the sequencer
// is idle. All products come from the single shared modular multiplier, one bit per cycle.
// Reset (rst, synchronous) clears the sequencer, empties the output and sets
// exponent to 0 and modulus to 1.
// ----------------------------------------------------------------------------
// Modular exponentiation
// Right-to-left square and multiply over a shared shift-and-add modular
// multiplier, with a configurable exponent and modulus.
// ----------------------------------------------------------------------------
`default_nettype none
`include "modular_exponentiation_defines.svh"

module modular_exponentiation #(
  parameter  int MODULUS_BITS = mexp_pkg::MODULUS_BITS_DEF,
  localparam int CfgWidth     = (MODULUS_BITS > mexp_pkg::EXP_BITS) ?
                                MODULUS_BITS : mexp_pkg::EXP_BITS
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // Configuration write port.
  input  wire logic                                cfg_write,
  input  wire logic [mexp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CfgWidth-1:0]                 cfg_data,
  // Input channel.
  input  wire logic                                in_valid,
  output      logic                                in_stall,
  input  wire logic [MODULUS_BITS-1:0]             base_value,
  // Output channel.
  output      logic                                out_valid,
  input  wire logic                                out_stall,
  output      logic [MODULUS_BITS-1:0]             power_result
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_NEXT,
    S_MULT,
    S_SQUARE,
    S_FINISH
  } state_t;

  state_t                          state;
  logic [mexp_pkg::EXP_BITS-1:0]   exponent;
  logic [MODULUS_BITS-1:0]         modulus;
  logic [mexp_pkg::EXP_BITS-1:0]   e_rem;
  logic [MODULUS_BITS-1:0]         acc;
  logic [MODULUS_BITS-1:0]         b;
  logic                            mul_start;
  logic                            mul_go;
  logic [MODULUS_BITS-1:0]         mul_x;
  logic [MODULUS_BITS-1:0]         mul_y;
  logic [MODULUS_BITS-1:0]         mul_product;
  mexp_pkg::mul_status_t           mul_status;
  logic [MODULUS_BITS-1:0]         one_mod;
  logic                            in_accept;
  logic                            out_free;
  logic                            out_load;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      exponent <= '0;
      modulus  <= MODULUS_BITS'(1);
    end else if (cfg_write) begin
      unique case (mexp_pkg::cfg_reg_t'(cfg_index))
        mexp_pkg::REG_EXPONENT: exponent <= cfg_data[mexp_pkg::EXP_BITS-1:0];
        mexp_pkg::REG_MODULUS:  modulus  <= cfg_data[MODULUS_BITS-1:0];
        default: ;
      endcase
    end
  end

  // One reduced modulo the modulus, which is zero for a modulus of one.
  assign one_mod   = (modulus == MODULUS_BITS'(1)) ? '0 : MODULUS_BITS'(1);
  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign out_load  = (state == S_FINISH) && out_free;

  // A product is launched whenever the sequencer moves into a multiply step.
  always_comb begin
    unique case (state)
      S_IDLE:  mul_go = in_accept && (modulus != '0);
      S_NEXT:  mul_go = (e_rem != '0);
      S_MULT:  mul_go = mul_status.done && (e_rem[mexp_pkg::EXP_BITS-1:1] != '0);
      default: mul_go = 1'b0;
    endcase
  end

  // Shared modular multiplier.
  mexp_mulmod #(
    .W (MODULUS_BITS)
  ) u_mulmod (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .x       (mul_x),
    .y       (mul_y),
    .m       (modulus),
    .product (mul_product),
    .status  (mul_status)
  );

  // Sequencer and output word register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mul_start <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      mul_start <= mul_go;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            e_rem <= exponent;
            if (modulus == '0) begin
              acc   <= '0;
              state <= S_FINISH;
            end else begin
              acc   <= one_mod;
              // Reduce the base as one_mod * base.
              mul_x <= one_mod;
              mul_y <= base_value;
              state <= S_REDUCE;
            end
          end
        end
        S_REDUCE: begin
          if (mul_status.done) begin
            b     <= mul_product;
            state <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (e_rem == '0) begin
            state <= S_FINISH;
          end else if (e_rem[0]) begin
            mul_x <= acc;
            mul_y <= b;
            state <= S_MULT;
          end else begin
            mul_x <= b;
            mul_y <= b;
            state <= S_SQUARE;
          end
        end
        S_MULT: begin
          if (mul_status.done) begin
            acc <= mul_product;
            // Skip the final squaring when no exponent bits remain.
            if (e_rem[mexp_pkg::EXP_BITS-1:1] == '0) begin
              state <= S_FINISH;
            end else begin
              mul_x <= b;
              mul_y <= b;
              state <= S_SQUARE;
            end
          end
        end
        S_SQUARE: begin
          if (mul_status.done) begin
            b     <= mul_product;
            e_rem <= {1'b0, e_rem[mexp_pkg::EXP_BITS-1:1]};
            state <= S_NEXT;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            power_result <= acc;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Multiplier results only arrive while the sequencer waits for them.
  `MEXP_ASSERT_SAME(a_done_when_waiting, mul_status.done,
                    state == S_REDUCE || state == S_MULT || state == S_SQUARE,
                    "multiplier result with no product pending")
  // Every delivered word is reduced below a nonzero modulus, or zero.
  `MEXP_ASSERT_SAME(a_result_range, $rose(out_valid),
                    (modulus == '0) ? (power_result == '0) : (power_result < modulus),
                    "result out of range")
  // A word is only loaded from the finish state.
  `MEXP_ASSERT_NEXT(a_load_from_finish, state == S_FINISH && out_free,
                    out_valid && state == S_IDLE, "finished word not loaded")

endmodule

`default_nettype wire
